// ----- rtl/direct_mapped_cache_write_through_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the direct-mapped write-through cache
// Shared property wrappers; all properties sample on clk_i and are
// disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef DIRECT_MAPPED_CACHE_WRITE_THROUGH_TOP_DEFINES_SVH
`define DIRECT_MAPPED_CACHE_WRITE_THROUGH_TOP_DEFINES_SVH

// Same-cycle implication.
`define DMCWT_ASSERT_NOW(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |-> (cons)) \
    else $error("cache assertion failed");

// Next-cycle implication.
`define DMCWT_ASSERT_NEXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ant) |=> (cons)) \
    else $error("cache assertion failed");

`endif

// ----- rtl/dmcwt_pkg.sv -----
// ----------------------------------------------------------------------------
// dmcwt_pkg
// Sizes, register indexes and divider interface types for the cache.
// ----------------------------------------------------------------------------
package dmcwt_pkg;

  localparam int MEM_WORDS = 1024;
  localparam int LINES     = 64;
  localparam int BLOCK_MAX = 16;

  localparam int DIV_W = 11;

  localparam logic [1:0] CFG_MEM_SIZE    = 2'd0;
  localparam logic [1:0] CFG_CACHE_WORDS = 2'd1;
  localparam logic [1:0] CFG_BLOCK_WORDS = 2'd2;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DIV_W-1:0] rem;
  } div_rsp_t;

endpackage

// ----- rtl/dmcwt_divider.sv -----
// ----------------------------------------------------------------------------
// dmcwt_divider
// Restoring divider, one quotient bit per cycle, shared by the sequencer.
// ----------------------------------------------------------------------------
module dmcwt_divider (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dmcwt_pkg::div_req_t req_i,
  output dmcwt_pkg::div_rsp_t rsp_o
);
  import dmcwt_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [DIV_W-1:0] rem_q, quo_q, dsr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             run_q, done_q;
  logic [DIV_W:0]   shifted, trial;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIV_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dsr_q <= req_i.divisor;
    end else if (run_q) begin
      if (!trial[DIV_W]) begin
        rem_q <= trial[DIV_W-1:0];
      end else begin
        rem_q <= shifted[DIV_W-1:0];
      end
      quo_q <= {quo_q[DIV_W-2:0], ~trial[DIV_W]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quo_q;
  assign rsp_o.rem  = rem_q;

endmodule

// ----- rtl/direct_mapped_cache_write_through_top.sv -----
// ----------------------------------------------------------------------------
// direct_mapped_cache_write_through_top
// Direct-mapped, write-through, write-allocate cache over a word memory.
// ----------------------------------------------------------------------------
// Raise start while busy is low to transfer one read or write. The result
// appears on the result ports for exactly one cycle with valid_o high and
// cannot be held off, so capture it on that cycle. Busy drops in the cycle the
// result shows, so the next item can be taken there. An access that passes the
// quick checks runs three passes of the shared bit-serial divider (load, 11
// quotient bits, done): cache size / block size for the geometry check,
// address / cache size, then that remainder / block size. ST_TAG then builds
// the slot base and ST_CMP compares the tag. A miss first fills the line,
// reading one block word per cycle from the main memory port, and ST_FILLW
// lands the last word. A zero size register, a memory size above 1024 words,
// a block size above 16 words or an address at or past mem_size gives
// error_o in the very next cycle and never raises busy; a cache size that is
// not a whole number of blocks or holds more than 64 lines gives error_o once
// the geometry division is done. All other result fields are zero on an
// error. After reset and after every write to one of the three size
// registers the block runs a clearing pass over all 1024 written-word flags,
// with busy high; register writes are always taken (cfg_ready_o is tied
// high), and those to the size registers restart that pass.
// ----------------------------------------------------------------------------
`include "direct_mapped_cache_write_through_top_defines.svh"

module direct_mapped_cache_write_through_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        cmd_i,
  input  logic [9:0]  address_i,
  input  logic signed [31:0] write_data_i,
  output logic        valid_o,
  output logic        hit_o,
  output logic        error_o,
  output logic [9:0]  tag_out_o,
  output logic [5:0]  line_out_o,
  output logic [3:0]  word_out_o,
  output logic signed [31:0] data_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import dmcwt_pkg::*;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_GEOM, ST_ADIV, ST_LDIV, ST_TAG,
    ST_CMP, ST_FILL, ST_FILLW, ST_ACCESS, ST_RDW
  } state_e;

  state_e state_q;

  // configuration
  logic [10:0] ms_q, cw_q;
  logic [4:0]  bw_q;

  // request and split address
  logic        cmd_q;
  logic [9:0]  addr_q;
  logic [31:0] wdata_q;
  logic [9:0]  tag_q;
  logic [5:0]  line_q;
  logic [3:0]  word_q;
  logic [9:0]  base_q;
  logic [9:0]  slot_base_q;
  logic [4:0]  k_q;
  logic        hit_q;
  logic [9:0]  clr_cnt_q;

  // fill pipeline
  logic        pend_q;
  logic [10:0] fill_idx_q;
  logic [9:0]  fill_slot_q;

  // results
  logic        valid_q, hit_out_q, err_q;
  logic [9:0]  tag_out_q;
  logic [5:0]  line_out_q;
  logic [3:0]  word_out_q;
  logic [31:0] data_out_q;

  logic [LINES-1:0] valid_bits_q;

  // memories
  logic [9:0]  tag_mem [LINES];
  logic [31:0] ld_mem  [MEM_WORDS];
  logic [31:0] main_mem[MEM_WORDS];
  logic        wr_mem  [MEM_WORDS];
  logic [9:0]  tag_rd_q;
  logic [31:0] ld_rd_q, main_rd_q;
  logic        wr_rd_q;

  div_req_t div_req_q;
  div_rsp_t div_rsp;

  dmcwt_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  logic        cfg_we;
  logic        accept;
  logic        quick_err;
  logic        hit_now;
  logic [10:0] fill_idx;
  logic [9:0]  slot_addr;
  logic [31:0] fill_val;
  logic [10:0] slot_prod;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;

  // cheap checks that need no divider
  assign quick_err = (bw_q == 5'd0) || (bw_q > 5'(BLOCK_MAX)) || (cw_q == 11'd0) ||
                     (ms_q == 11'd0) || (ms_q > 11'(MEM_WORDS)) ||
                     ({1'b0, address_i} >= ms_q);

  assign hit_now   = valid_bits_q[line_q] && (tag_rd_q == tag_q);
  assign fill_idx  = {1'b0, base_q} + {6'd0, k_q};
  assign slot_addr = slot_base_q + {6'd0, word_q};
  assign slot_prod = {5'd0, line_q} * {6'd0, bw_q};

  // word past the end or never written takes mem_size - index
  assign fill_val = (!fill_idx_q[10] && (fill_idx_q < ms_q) && wr_rd_q) ? main_rd_q :
                    ({21'd0, ms_q} - {21'd0, fill_idx_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      ms_q         <= 11'(MEM_WORDS);
      cw_q         <= 11'd64;
      bw_q         <= 5'd4;
      valid_bits_q <= '0;
      valid_q      <= 1'b0;
      pend_q       <= 1'b0;
      div_req_q    <= '0;
      k_q          <= '0;
    end else begin
      valid_q         <= 1'b0;
      div_req_q.start <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + 1'b1;
          if (clr_cnt_q == 10'(MEM_WORDS - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cmd_q   <= cmd_i;
            addr_q  <= address_i;
            wdata_q <= write_data_i;
            if (quick_err) begin
              valid_q    <= 1'b1;
              err_q      <= 1'b1;
              hit_out_q  <= 1'b0;
              tag_out_q  <= '0;
              line_out_q <= '0;
              word_out_q <= '0;
              data_out_q <= '0;
            end else begin
              div_req_q <= '{start: 1'b1, dividend: cw_q, divisor: {6'd0, bw_q}};
              state_q   <= ST_GEOM;
            end
          end
        end
        ST_GEOM: begin
          if (div_rsp.done) begin
            if ((div_rsp.rem != '0) || (div_rsp.quot > 11'(LINES))) begin
              valid_q    <= 1'b1;
              err_q      <= 1'b1;
              hit_out_q  <= 1'b0;
              tag_out_q  <= '0;
              line_out_q <= '0;
              word_out_q <= '0;
              data_out_q <= '0;
              state_q    <= ST_IDLE;
            end else begin
              div_req_q <= '{start: 1'b1, dividend: {1'b0, addr_q}, divisor: cw_q};
              state_q   <= ST_ADIV;
            end
          end
        end
        ST_ADIV: begin
          if (div_rsp.done) begin
            tag_q     <= div_rsp.quot[9:0];
            div_req_q <= '{start: 1'b1, dividend: div_rsp.rem, divisor: {6'd0, bw_q}};
            state_q   <= ST_LDIV;
          end
        end
        ST_LDIV: begin
          if (div_rsp.done) begin
            line_q  <= div_rsp.quot[5:0];
            word_q  <= div_rsp.rem[3:0];
            base_q  <= addr_q - div_rsp.rem[9:0];
            state_q <= ST_TAG;
          end
        end
        ST_TAG: begin
          slot_base_q <= slot_prod[9:0];
          state_q     <= ST_CMP;
        end
        ST_CMP: begin
          hit_q <= hit_now;
          if (hit_now) begin
            state_q <= ST_ACCESS;
          end else begin
            valid_bits_q[line_q] <= 1'b1;
            k_q                  <= '0;
            state_q              <= ST_FILL;
          end
        end
        ST_FILL: begin
          // issue one memory read a cycle; the previous word lands behind it
          pend_q      <= 1'b1;
          fill_idx_q  <= fill_idx;
          fill_slot_q <= slot_base_q + {5'd0, k_q};
          k_q         <= k_q + 1'b1;
          if (k_q == bw_q - 1'b1) begin
            state_q <= ST_FILLW;
          end
        end
        ST_FILLW: begin
          pend_q  <= 1'b0;
          state_q <= ST_ACCESS;
        end
        ST_ACCESS: begin
          if (cmd_q) begin
            valid_q    <= 1'b1;
            err_q      <= 1'b0;
            hit_out_q  <= hit_q;
            tag_out_q  <= tag_q;
            line_out_q <= line_q;
            word_out_q <= word_q;
            data_out_q <= wdata_q;
            state_q    <= ST_IDLE;
          end else begin
            state_q <= ST_RDW;
          end
        end
        ST_RDW: begin
          valid_q    <= 1'b1;
          err_q      <= 1'b0;
          hit_out_q  <= hit_q;
          tag_out_q  <= tag_q;
          line_out_q <= line_q;
          word_out_q <= word_q;
          data_out_q <= ld_rd_q;
          state_q    <= ST_IDLE;
        end
        default: begin
          state_q <= ST_CLEAR;
        end
      endcase
      // a write to any size register drops all lines and restarts the flag sweep
      if (cfg_we && (cfg_index_i == CFG_MEM_SIZE || cfg_index_i == CFG_CACHE_WORDS ||
                     cfg_index_i == CFG_BLOCK_WORDS)) begin
        unique case (cfg_index_i)
          CFG_MEM_SIZE:    ms_q <= cfg_data_i;
          CFG_CACHE_WORDS: cw_q <= cfg_data_i;
          default:         bw_q <= cfg_data_i[4:0];
        endcase
        valid_bits_q <= '0;
        clr_cnt_q    <= '0;
        pend_q       <= 1'b0;
        state_q      <= ST_CLEAR;
      end
    end
  end

  // tag store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CMP && !hit_now) begin
      tag_mem[line_q] <= tag_q;
    end
    tag_rd_q <= tag_mem[line_q];
  end

  // line data store: fill words, then the write hit/allocate word
  always_ff @(posedge clk_i) begin
    if (pend_q) begin
      ld_mem[fill_slot_q] <= fill_val;
    end else if (state_q == ST_ACCESS && cmd_q) begin
      ld_mem[slot_addr] <= wdata_q;
    end
    ld_rd_q <= ld_mem[slot_addr];
  end

  // main memory, written through on every store
  always_ff @(posedge clk_i) begin
    if (state_q == ST_ACCESS && cmd_q) begin
      main_mem[addr_q] <= wdata_q;
    end
    main_rd_q <= main_mem[fill_idx[9:0]];
  end

  // written-word flags, swept clear after reset and size-register writes
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      wr_mem[clr_cnt_q] <= 1'b0;
    end else if (state_q == ST_ACCESS && cmd_q) begin
      wr_mem[addr_q] <= 1'b1;
    end
    wr_rd_q <= wr_mem[fill_idx[9:0]];
  end

  assign valid_o    = valid_q;
  assign hit_o      = hit_out_q;
  assign error_o    = err_q;
  assign tag_out_o  = tag_out_q;
  assign line_out_o = line_out_q;
  assign word_out_o = word_out_q;
  assign data_out_o = data_out_q;

  // only a quick-check error can follow another result in the next cycle
  `DMCWT_ASSERT_NEXT(a_accept_busy, accept && !quick_err && !cfg_we, busy)
  `DMCWT_ASSERT_NOW(a_err_clean, valid_o && error_o, !hit_o && data_out_o == 32'd0)
  `DMCWT_ASSERT_NEXT(a_strobe_single, valid_o, !valid_o || error_o)
  `DMCWT_ASSERT_NOW(a_fill_only_in_fill, pend_q, state_q == ST_FILL || state_q == ST_FILLW)

endmodule
